### sv/ihl_pkg.sv
// Integer Haar lifting unit: shared types and constants.
// Sequencer states, shared-unit operation codes, control bundle, register map.
// No dependencies.
package ihl_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CP_RD,
    ST_CP_WR,
    ST_F_RDA,
    ST_F_RDB,
    ST_F_SUM,
    ST_F_DET,
    ST_F_RT_RD,
    ST_F_RT_WR,
    ST_I_RD0,
    ST_I_WR0,
    ST_I_RDS,
    ST_I_B,
    ST_I_A,
    ST_EM_RD,
    ST_EM_LD
  } state_t;

  typedef enum logic [2:0] {
    OP_BLK_SUB_DC,
    OP_SUM,
    OP_DET,
    OP_PASS_W,
    OP_PASS_B,
    OP_INV_B,
    OP_INV_A,
    OP_W_ADD_DC
  } alu_op_t;

  typedef enum logic [1:0] {
    OPA_HOLD,
    OPA_WRD,
    OPA_ALU
  } opa_sel_t;

  typedef enum logic [1:0] {
    OPB_HOLD,
    OPB_WRD,
    OPB_ALU
  } opb_sel_t;

  typedef struct packed {
    logic     w_we;
    logic     b_we;
    logic     b_wr_in;
    alu_op_t  alu_op;
    opa_sel_t opa_sel;
    opb_sel_t opb_sel;
    logic     out_ld;
    logic     out_last;
  } ctl_t;

  localparam logic [1:0] REG_DIRECTION = 2'd0;
  localparam logic [1:0] REG_SIZE_LOG2 = 2'd1;
  localparam logic [1:0] REG_DC_OFFSET = 2'd2;

  localparam logic       DIR_FORWARD   = 1'b0;
  localparam int         LOG2_W        = 3;
  localparam int         DC_W          = 16;
  localparam logic [2:0] MIN_SIZE_LOG2 = 3'd2;
  localparam logic [2:0] RESET_LOG2    = 3'd6;

endpackage

### sv/ihl_in_if.sv
// Input stream channel: valid/ready handshake with one value per beat.
// No dependencies.
interface ihl_in_if #(
  parameter int W = 24
);
  logic         valid;
  logic         ready;
  logic [W-1:0] value_in;

  modport source (output valid, output value_in, input ready);
  modport sink   (input valid, input value_in, output ready);
endinterface

### sv/ihl_out_if.sv
// Result stream channel: valid/ready handshake, one value and block-end flag per beat.
// No dependencies.
interface ihl_out_if #(
  parameter int W = 24
);
  logic         valid;
  logic         ready;
  logic [W-1:0] value_out;
  logic         last_out;

  modport source (output valid, output value_out, output last_out, input ready);
  modport sink   (input valid, input value_out, input last_out, output ready);
endinterface

### sv/integer_haar_lifting_transform_unit.sv
// Block integer Haar lifting unit: one input beat per cycle while filling a block of L values.
// Forward: copies the block less the DC offset to work memory, then sum/detail passes per level, root copy, emit.
// Inverse: copies the root to work memory, then lifting passes per level, emit with the DC offset added back.
// The transform uses the single add/subtract unit and one read port per memory; input is held off meanwhile.
// Synchronous active-high rst clears the sequencer, fill count and result valid, and sets config registers to defaults.
module integer_haar_lifting_transform_unit #(
  parameter int MAX_BLOCK   = 64,
  parameter int VALUE_WIDTH = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  ihl_in_if.sink       samples,
  ihl_out_if.source    results
);

  localparam int AW = $clog2(MAX_BLOCK);
  localparam int CW = AW + 1;

  logic                             direction;
  logic [ihl_pkg::LOG2_W-1:0]       size_log2;
  logic [ihl_pkg::DC_W-1:0]         dc_offset;
  logic                             cfg_wr;
  ihl_pkg::ctl_t                    ctl;
  logic [AW-1:0]                    w_raddr;
  logic [AW-1:0]                    w_waddr;
  logic [AW-1:0]                    b_raddr;
  logic [AW-1:0]                    b_waddr;
  logic                             out_busy;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= ihl_pkg::DIR_FORWARD;
      size_log2 <= ihl_pkg::RESET_LOG2;
      dc_offset <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        ihl_pkg::REG_DIRECTION: direction <= pwdata[0];
        ihl_pkg::REG_SIZE_LOG2: size_log2 <= pwdata[ihl_pkg::LOG2_W-1:0];
        ihl_pkg::REG_DC_OFFSET: dc_offset <= pwdata[ihl_pkg::DC_W-1:0];
        default: begin
          direction <= direction;
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ihl_pkg::REG_DIRECTION: prdata = {31'd0, direction};
      ihl_pkg::REG_SIZE_LOG2: prdata = {{(32 - ihl_pkg::LOG2_W){1'b0}}, size_log2};
      ihl_pkg::REG_DC_OFFSET: prdata = {{(32 - ihl_pkg::DC_W){1'b0}}, dc_offset};
      default:                prdata = '0;
    endcase
  end

  ihl_seq #(
    .MAX_BLOCK (MAX_BLOCK),
    .AW        (AW),
    .CW        (CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .dir       (direction),
    .size_log2 (size_log2),
    .out_busy  (out_busy),
    .in_ready  (samples.ready),
    .ctl       (ctl),
    .w_raddr   (w_raddr),
    .w_waddr   (w_waddr),
    .b_raddr   (b_raddr),
    .b_waddr   (b_waddr)
  );

  ihl_dp #(
    .MAX_BLOCK (MAX_BLOCK),
    .W         (VALUE_WIDTH),
    .AW        (AW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .w_raddr   (w_raddr),
    .w_waddr   (w_waddr),
    .b_raddr   (b_raddr),
    .b_waddr   (b_waddr),
    .value_in  (samples.value_in),
    .dc        (dc_offset),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .value_out (results.value_out),
    .last_out  (results.last_out),
    .out_busy  (out_busy)
  );

endmodule

### sv/ihl_alu.sv
// Shared add/subtract unit with optional arithmetic halving of the first operand.
// No dependencies.
module ihl_alu #(
  parameter int W = 24
) (
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic         half_x,
  input  logic         sub,
  output logic [W-1:0] r
);

  logic [W-1:0] xs;

  always_comb begin
    xs = half_x ? {x[W-1], x[W-1:1]} : x;
    r  = sub ? (xs - y) : (xs + y);
  end

endmodule

### sv/ihl_dp.sv
// Datapath: block and work memories, operand registers, shared unit, result register.
// Depends on ihl_pkg and ihl_alu.
module ihl_dp #(
  parameter int MAX_BLOCK = 64,
  parameter int W         = 24,
  parameter int AW        = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ihl_pkg::ctl_t          ctl,
  input  logic [AW-1:0]          w_raddr,
  input  logic [AW-1:0]          w_waddr,
  input  logic [AW-1:0]          b_raddr,
  input  logic [AW-1:0]          b_waddr,
  input  logic [W-1:0]           value_in,
  input  logic [ihl_pkg::DC_W-1:0] dc,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [W-1:0]           value_out,
  output logic                   last_out,
  output logic                   out_busy
);

  logic [W-1:0] wmem [MAX_BLOCK];
  logic [W-1:0] bmem [MAX_BLOCK];
  logic [W-1:0] w_rd;
  logic [W-1:0] b_rd;
  logic [W-1:0] opa;
  logic [W-1:0] opb;
  logic [W-1:0] dc_w;
  logic [W-1:0] alu_x;
  logic [W-1:0] alu_y;
  logic         alu_half;
  logic         alu_sub;
  logic [W-1:0] alu_r;
  logic [W-1:0] b_wdata;

  assign dc_w    = {{(W - ihl_pkg::DC_W){dc[ihl_pkg::DC_W-1]}}, dc};
  assign b_wdata = ctl.b_wr_in ? value_in : alu_r;
  assign out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (ctl.w_we) begin
      wmem[w_waddr] <= alu_r;
    end
    w_rd <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.b_we) begin
      bmem[b_waddr] <= b_wdata;
    end
    b_rd <= bmem[b_raddr];
  end

  always_comb begin
    alu_x    = w_rd;
    alu_y    = '0;
    alu_half = 1'b0;
    alu_sub  = 1'b0;
    unique case (ctl.alu_op)
      ihl_pkg::OP_BLK_SUB_DC: begin
        alu_x   = b_rd;
        alu_y   = dc_w;
        alu_sub = 1'b1;
      end
      ihl_pkg::OP_SUM: begin
        alu_x = opa;
        alu_y = w_rd;
      end
      ihl_pkg::OP_DET: begin
        alu_x    = opa;
        alu_y    = opb;
        alu_half = 1'b1;
        alu_sub  = 1'b1;
      end
      ihl_pkg::OP_PASS_W: begin
        alu_x = w_rd;
      end
      ihl_pkg::OP_PASS_B: begin
        alu_x = b_rd;
      end
      ihl_pkg::OP_INV_B: begin
        alu_x    = w_rd;
        alu_y    = b_rd;
        alu_half = 1'b1;
        alu_sub  = 1'b1;
      end
      ihl_pkg::OP_INV_A: begin
        alu_x   = opa;
        alu_y   = opb;
        alu_sub = 1'b1;
      end
      ihl_pkg::OP_W_ADD_DC: begin
        alu_x = w_rd;
        alu_y = dc_w;
      end
      default: begin
        alu_x = w_rd;
      end
    endcase
  end

  ihl_alu #(
    .W(W)
  ) u_alu (
    .x      (alu_x),
    .y      (alu_y),
    .half_x (alu_half),
    .sub    (alu_sub),
    .r      (alu_r)
  );

  always_ff @(posedge clk) begin
    unique case (ctl.opa_sel)
      ihl_pkg::OPA_WRD: opa <= w_rd;
      ihl_pkg::OPA_ALU: opa <= alu_r;
      default:          opa <= opa;
    endcase
    unique case (ctl.opb_sel)
      ihl_pkg::OPB_WRD: opb <= w_rd;
      ihl_pkg::OPB_ALU: opb <= alu_r;
      default:          opb <= opb;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      value_out <= alu_r;
      last_out  <= ctl.out_last;
    end
  end

endmodule

### sv/ihl_seq.sv
// Sequencer: block fill, forward and inverse lifting passes, result emission.
// Depends on ihl_pkg.
module ihl_seq #(
  parameter int MAX_BLOCK = 64,
  parameter int AW        = 6,
  parameter int CW        = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       dir,
  input  logic [ihl_pkg::LOG2_W-1:0] size_log2,
  input  logic                       out_busy,
  output logic                       in_ready,
  output ihl_pkg::ctl_t              ctl,
  output logic [AW-1:0]              w_raddr,
  output logic [AW-1:0]              w_waddr,
  output logic [AW-1:0]              b_raddr,
  output logic [AW-1:0]              b_waddr
);

  ihl_pkg::state_t state;
  ihl_pkg::state_t state_next;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_next;
  logic [CW-1:0] span;
  logic [CW-1:0] span_next;
  logic [CW-1:0] blen;
  logic [CW-1:0] blen_next;

  logic [ihl_pkg::LOG2_W-1:0] lg;
  logic [7:0]                 len_full;
  logic [CW-1:0]              len_cur;
  logic [CW-1:0]              fill_inc;
  logic [CW-1:0]              span2;
  logic                       accept;

  always_comb begin
    lg       = (size_log2 < ihl_pkg::MIN_SIZE_LOG2) ? ihl_pkg::MIN_SIZE_LOG2 : size_log2;
    len_full = 8'd1 << lg;
    len_cur  = (int'(len_full) > MAX_BLOCK) ? CW'(MAX_BLOCK) : CW'(len_full);
    fill_inc = fill + CW'(1);
    span2    = {span[CW-2:0], 1'b0};
    accept   = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ihl_pkg::ST_IDLE;
      fill  <= '0;
      idx   <= '0;
      span  <= '0;
      blen  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      idx   <= idx_next;
      span  <= span_next;
      blen  <= blen_next;
    end
  end

  always_comb begin
    state_next = state;
    fill_next  = fill;
    idx_next   = idx;
    span_next  = span;
    blen_next  = blen;
    unique case (state)
      ihl_pkg::ST_IDLE: begin
        if (accept) begin
          if (fill_inc >= len_cur) begin
            fill_next  = '0;
            blen_next  = len_cur;
            idx_next   = '0;
            state_next = (dir == ihl_pkg::DIR_FORWARD) ? ihl_pkg::ST_CP_RD : ihl_pkg::ST_I_RD0;
          end else begin
            fill_next = fill_inc;
          end
        end
      end
      ihl_pkg::ST_CP_RD: state_next = ihl_pkg::ST_CP_WR;
      ihl_pkg::ST_CP_WR: begin
        if (idx == blen - CW'(1)) begin
          idx_next   = '0;
          span_next  = blen >> 1;
          state_next = ihl_pkg::ST_F_RDA;
        end else begin
          idx_next   = idx + CW'(1);
          state_next = ihl_pkg::ST_CP_RD;
        end
      end
      ihl_pkg::ST_F_RDA: state_next = ihl_pkg::ST_F_RDB;
      ihl_pkg::ST_F_RDB: state_next = ihl_pkg::ST_F_SUM;
      ihl_pkg::ST_F_SUM: state_next = ihl_pkg::ST_F_DET;
      ihl_pkg::ST_F_DET: begin
        if (idx == span - CW'(1)) begin
          idx_next = '0;
          if (span == CW'(1)) begin
            state_next = ihl_pkg::ST_F_RT_RD;
          end else begin
            span_next  = span >> 1;
            state_next = ihl_pkg::ST_F_RDA;
          end
        end else begin
          idx_next   = idx + CW'(1);
          state_next = ihl_pkg::ST_F_RDA;
        end
      end
      ihl_pkg::ST_F_RT_RD: state_next = ihl_pkg::ST_F_RT_WR;
      ihl_pkg::ST_F_RT_WR: begin
        idx_next   = '0;
        state_next = ihl_pkg::ST_EM_RD;
      end
      ihl_pkg::ST_I_RD0: state_next = ihl_pkg::ST_I_WR0;
      ihl_pkg::ST_I_WR0: begin
        span_next  = CW'(1);
        idx_next   = '0;
        state_next = ihl_pkg::ST_I_RDS;
      end
      ihl_pkg::ST_I_RDS: state_next = ihl_pkg::ST_I_B;
      ihl_pkg::ST_I_B:   state_next = ihl_pkg::ST_I_A;
      ihl_pkg::ST_I_A: begin
        if (idx == '0) begin
          if (span2 >= blen) begin
            state_next = ihl_pkg::ST_EM_RD;
          end else begin
            span_next  = span2;
            idx_next   = span2 - CW'(1);
            state_next = ihl_pkg::ST_I_RDS;
          end
        end else begin
          idx_next   = idx - CW'(1);
          state_next = ihl_pkg::ST_I_RDS;
        end
      end
      ihl_pkg::ST_EM_RD: state_next = ihl_pkg::ST_EM_LD;
      ihl_pkg::ST_EM_LD: begin
        if (!out_busy) begin
          if (idx == blen - CW'(1)) begin
            state_next = ihl_pkg::ST_IDLE;
          end else begin
            idx_next   = idx + CW'(1);
            state_next = ihl_pkg::ST_EM_RD;
          end
        end
      end
      default: state_next = ihl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.alu_op = ihl_pkg::OP_PASS_B;
    in_ready   = 1'b0;
    w_raddr    = '0;
    w_waddr    = '0;
    b_raddr    = '0;
    b_waddr    = '0;
    unique case (state)
      ihl_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.b_we    = accept;
        ctl.b_wr_in = 1'b1;
        b_waddr     = fill[AW-1:0];
      end
      ihl_pkg::ST_CP_RD: b_raddr = idx[AW-1:0];
      ihl_pkg::ST_CP_WR: begin
        ctl.alu_op = ihl_pkg::OP_BLK_SUB_DC;
        ctl.w_we   = 1'b1;
        w_waddr    = idx[AW-1:0];
      end
      ihl_pkg::ST_F_RDA: w_raddr = AW'({idx, 1'b0});
      ihl_pkg::ST_F_RDB: begin
        w_raddr     = AW'({idx, 1'b1});
        ctl.opa_sel = ihl_pkg::OPA_WRD;
      end
      ihl_pkg::ST_F_SUM: begin
        ctl.alu_op  = ihl_pkg::OP_SUM;
        ctl.w_we    = 1'b1;
        w_waddr     = idx[AW-1:0];
        ctl.opa_sel = ihl_pkg::OPA_ALU;
        ctl.opb_sel = ihl_pkg::OPB_WRD;
      end
      ihl_pkg::ST_F_DET: begin
        ctl.alu_op = ihl_pkg::OP_DET;
        ctl.b_we   = 1'b1;
        b_waddr    = AW'(span + idx);
      end
      ihl_pkg::ST_F_RT_RD: w_raddr = '0;
      ihl_pkg::ST_F_RT_WR: begin
        ctl.alu_op = ihl_pkg::OP_PASS_W;
        ctl.b_we   = 1'b1;
        b_waddr    = '0;
      end
      ihl_pkg::ST_I_RD0: b_raddr = '0;
      ihl_pkg::ST_I_WR0: begin
        ctl.alu_op = ihl_pkg::OP_PASS_B;
        ctl.w_we   = 1'b1;
        w_waddr    = '0;
      end
      ihl_pkg::ST_I_RDS: begin
        w_raddr = idx[AW-1:0];
        b_raddr = AW'(span + idx);
      end
      ihl_pkg::ST_I_B: begin
        ctl.alu_op  = ihl_pkg::OP_INV_B;
        ctl.w_we    = 1'b1;
        w_waddr     = AW'({idx, 1'b1});
        ctl.opa_sel = ihl_pkg::OPA_WRD;
        ctl.opb_sel = ihl_pkg::OPB_ALU;
      end
      ihl_pkg::ST_I_A: begin
        ctl.alu_op = ihl_pkg::OP_INV_A;
        ctl.w_we   = 1'b1;
        w_waddr    = AW'({idx, 1'b0});
      end
      ihl_pkg::ST_EM_RD: begin
        w_raddr = idx[AW-1:0];
        b_raddr = idx[AW-1:0];
      end
      ihl_pkg::ST_EM_LD: begin
        w_raddr      = idx[AW-1:0];
        b_raddr      = idx[AW-1:0];
        ctl.alu_op   = (dir == ihl_pkg::DIR_FORWARD) ? ihl_pkg::OP_PASS_B
                                                     : ihl_pkg::OP_W_ADD_DC;
        ctl.out_ld   = !out_busy;
        ctl.out_last = (idx == blen - CW'(1));
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state == ihl_pkg::ST_IDLE |-> fill < CW'(MAX_BLOCK))
    else $error("fill count past block capacity");

  a_blen_min: assert property (@(posedge clk) disable iff (rst)
    state != ihl_pkg::ST_IDLE |-> blen >= CW'(4))
    else $error("block length below four during transform");

  a_inv_span_pow2: assert property (@(posedge clk) disable iff (rst)
    state == ihl_pkg::ST_I_RDS |-> $onehot(span))
    else $error("inverse level span not a power of two");

  a_pair_in_level: assert property (@(posedge clk) disable iff (rst)
    (state == ihl_pkg::ST_F_DET || state == ihl_pkg::ST_I_A) |-> idx < span)
    else $error("pair index outside current level");

  a_complete_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && fill_inc >= len_cur) |=> state != ihl_pkg::ST_IDLE && fill == '0)
    else $error("completed block did not start transform");
`endif

endmodule
